[design/cpu8_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_pkg
// Shared types, the code page 1252 high-half table and its reverse lookup.
// ----------------------------------------------------------------------------
package cpu8_pkg;

    // one classified item: up to three output words and their flags
    typedef struct packed {
        logic [1:0]      cnt;      // number of words, 1 to 3
        logic [2:0][7:0] bytes;    // word 0 goes out first
        logic            bad;
        logic            str_end;
    } t_job;

    typedef struct packed {
        logic       ok;
        logic [7:0] code;
    } t_map;

    // code points of 1252 bytes 80-9F; zero marks an undefined code
    function automatic logic [15:0] high_cp(input logic [4:0] idx);
        logic [15:0] cp;
        unique case (idx)
            5'd0:  cp = 16'h20AC;
            5'd1:  cp = 16'h0000;
            5'd2:  cp = 16'h201A;
            5'd3:  cp = 16'h0192;
            5'd4:  cp = 16'h201E;
            5'd5:  cp = 16'h2026;
            5'd6:  cp = 16'h2020;
            5'd7:  cp = 16'h2021;
            5'd8:  cp = 16'h02C6;
            5'd9:  cp = 16'h2030;
            5'd10: cp = 16'h0160;
            5'd11: cp = 16'h2039;
            5'd12: cp = 16'h0152;
            5'd13: cp = 16'h0000;
            5'd14: cp = 16'h017D;
            5'd15: cp = 16'h0000;
            5'd16: cp = 16'h0000;
            5'd17: cp = 16'h2018;
            5'd18: cp = 16'h2019;
            5'd19: cp = 16'h201C;
            5'd20: cp = 16'h201D;
            5'd21: cp = 16'h2022;
            5'd22: cp = 16'h2013;
            5'd23: cp = 16'h2014;
            5'd24: cp = 16'h02DC;
            5'd25: cp = 16'h2122;
            5'd26: cp = 16'h0161;
            5'd27: cp = 16'h203A;
            5'd28: cp = 16'h0153;
            5'd29: cp = 16'h0000;
            5'd30: cp = 16'h017E;
            5'd31: cp = 16'h0178;
            default: cp = 16'h0000;
        endcase
        return cp;
    endfunction

    // map a code point back to a 1252 byte; compares run in parallel
    function automatic t_map to_1252(input logic [15:0] cp);
        t_map        m;
        logic [15:0] ent;
        m.ok   = 1'b0;
        m.code = 8'h00;
        if (cp < 16'h0080 || (cp >= 16'h00A0 && cp <= 16'h00FF)) begin
            m.ok   = 1'b1;
            m.code = cp[7:0];
        end else begin
            for (int i = 0; i < 32; i++) begin
                ent = high_cp(5'(i));
                if (ent != 16'h0000 && ent == cp) begin
                    m.ok   = 1'b1;
                    m.code = 8'h80 | 8'(i);
                end
            end
        end
        return m;
    endfunction

endpackage

[design/cp1252_utf8_transcoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp1252_utf8_transcoder_core
// Windows-1252 to UTF-8 and UTF-8 to Windows-1252 transcoder, one word in.
// ----------------------------------------------------------------------------
// The front part takes one input word per cycle whenever the two-entry job
// queue has room, and the back part sends one output word per cycle while
// the output is not stalled. An encoded character gives one to three output
// words, so the single output port sets the sustained rate; decode words
// that open or extend a sequence give no output. An accepted word's job goes
// through a queue entry and the back part's job register before it is sent.
// Write the encoding register only while the block is idle.
module cp1252_utf8_transcoder_core
    import cpu8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_op,
    input  logic [7:0] i_in_byte,
    input  logic       i_string_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_bad_char,
    output logic       o_run_last,
    output logic       o_string_end
);

    logic r_active;
    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job f_job;
    t_job q_job;

    // hold the encoding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    cpu8_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_active      (r_active),
        .i_accept      (accept),
        .i_op          (i_op),
        .i_in_byte     (i_in_byte),
        .i_string_last (i_string_last),
        .o_push        (push),
        .o_job         (f_job)
    );

    cpu8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (q_job)
    );

    cpu8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_job        (q_job),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_bad_char   (o_bad_char),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

endmodule

[design/cpu8_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_front
// Accepts input words, tracks the UTF-8 sequence and string state, and
// classifies each word into a job of zero to three output words.
// ----------------------------------------------------------------------------
module cpu8_front
    import cpu8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_active,
    input  logic       i_accept,
    input  logic       i_op,
    input  logic [7:0] i_in_byte,
    input  logic       i_string_last,
    output logic       o_push,
    output t_job       o_job
);

    logic [15:0] r_pcode,  n_pcode;
    logic [1:0]  r_pcount, n_pcount;
    logic [1:0]  r_seqlen, n_seqlen;
    logic        r_failed, n_failed;

    logic        do_err;
    logic        do_map;
    logic [15:0] map_cp;
    logic [15:0] enc_cp;
    logic [15:0] cont_code;
    t_map        map_res;

    // hold sequence and string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcode  <= '0;
            r_pcount <= '0;
            r_seqlen <= '0;
            r_failed <= 1'b0;
        end else begin
            r_pcode  <= n_pcode;
            r_pcount <= n_pcount;
            r_seqlen <= n_seqlen;
            r_failed <= n_failed;
        end
    end

    assign enc_cp    = (i_in_byte[7:5] == 3'b100) ? high_cp(i_in_byte[4:0])
                                                  : {8'h00, i_in_byte};
    assign cont_code = {r_pcode[9:0], i_in_byte[5:0]};
    assign map_res   = to_1252(map_cp);

    // classify the word and advance the state
    always_comb begin
        n_pcode  = r_pcode;
        n_pcount = r_pcount;
        n_seqlen = r_seqlen;
        n_failed = r_failed;
        do_err   = 1'b0;
        do_map   = 1'b0;
        map_cp   = {8'h00, i_in_byte};
        o_push   = 1'b0;
        o_job    = '0;
        o_job.str_end = i_string_last;

        if (i_accept) begin
            priority if (r_failed) begin
                do_err = i_string_last;
            end else if (!i_active) begin
                do_err = 1'b1;
            end else if (!i_op) begin
                // encode one 1252 byte
                if (r_pcount != 2'd0 || enc_cp == 16'h0000 && i_in_byte[7]) begin
                    do_err = 1'b1;
                end else begin
                    o_push = 1'b1;
                    if (i_string_last) begin
                        n_failed = 1'b0;
                    end
                    priority if (enc_cp < 16'h0080) begin
                        o_job.cnt      = 2'd1;
                        o_job.bytes[0] = enc_cp[7:0];
                    end else if (enc_cp < 16'h0800) begin
                        o_job.cnt      = 2'd2;
                        o_job.bytes[0] = {3'b110, enc_cp[10:6]};
                        o_job.bytes[1] = {2'b10, enc_cp[5:0]};
                    end else begin
                        o_job.cnt      = 2'd3;
                        o_job.bytes[0] = {4'hE, enc_cp[15:12]};
                        o_job.bytes[1] = {2'b10, enc_cp[11:6]};
                        o_job.bytes[2] = {2'b10, enc_cp[5:0]};
                    end
                end
            end else if (r_pcount == 2'd0) begin
                // decode a lead byte
                priority if (!i_in_byte[7]) begin
                    do_map = 1'b1;
                end else if (i_in_byte >= 8'hC2 && i_in_byte <= 8'hDF) begin
                    n_pcode  = {11'd0, i_in_byte[4:0]};
                    n_pcount = 2'd1;
                    n_seqlen = 2'd2;
                    do_err   = i_string_last;
                end else if (i_in_byte[7:4] == 4'hE) begin
                    n_pcode  = {12'd0, i_in_byte[3:0]};
                    n_pcount = 2'd2;
                    n_seqlen = 2'd3;
                    do_err   = i_string_last;
                end else begin
                    do_err = 1'b1;
                end
            end else if (i_in_byte[7:6] != 2'b10) begin
                do_err = 1'b1;
            end else begin
                // decode a continuation byte
                n_pcode  = cont_code;
                n_pcount = r_pcount - 2'd1;
                if (r_pcount != 2'd1) begin
                    do_err = i_string_last;
                end else if (r_seqlen == 2'd3 && cont_code < 16'h0800) begin
                    do_err = 1'b1;
                end else begin
                    do_map = 1'b1;
                    map_cp = cont_code;
                end
            end

            // emit a decoded code point
            if (do_map) begin
                if (map_res.ok) begin
                    n_pcode  = '0;
                    n_pcount = '0;
                    n_seqlen = '0;
                    if (i_string_last) begin
                        n_failed = 1'b0;
                    end
                    o_push         = 1'b1;
                    o_job.cnt      = 2'd1;
                    o_job.bytes[0] = map_res.code;
                end else begin
                    do_err = 1'b1;
                end
            end

            // drop the sequence and report the error
            if (do_err) begin
                n_pcode   = '0;
                n_pcount  = '0;
                n_seqlen  = '0;
                n_failed  = !i_string_last;
                o_push    = 1'b1;
                o_job.cnt = 2'd1;
                o_job.bytes = '0;
                o_job.bad = 1'b1;
            end
        end
    end

endmodule

[design/cpu8_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module cpu8_queue
    import cpu8_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // advance pointers and fill level
    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // store the pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

[design/cpu8_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_back
// Takes jobs from the queue and sends their words out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module cpu8_back
    import cpu8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_bad_char,
    output logic       o_run_last,
    output logic       o_string_end
);

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_idx, n_idx;
    logic       done;

    assign o_out_valid  = r_busy;
    assign o_out_byte   = r_job.bytes[r_idx];
    assign o_bad_char   = r_job.bad;
    assign o_run_last   = (r_idx == r_job.cnt - 2'd1);
    assign o_string_end = r_job.str_end;

    assign done  = r_busy && !i_out_stall && o_run_last;
    assign o_pop = !i_empty && (!r_busy || done);

    // step through the words of the current job
    always_comb begin
        n_idx = r_idx;
        if (o_pop) begin
            n_idx = 2'd0;
        end else if (r_busy && !i_out_stall) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_idx <= n_idx;
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // load the next job
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

endmodule

[design/cpu8_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_checker
// Port-level checks on the transcoder output, bound to the top level.
// ----------------------------------------------------------------------------
module cpu8_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_bad_char,
    input logic       o_run_last,
    input logic       o_string_end
);

    // hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_run_last))
        else $error("stalled output word changed");

    // an error word is a lone zero word
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_char |-> o_run_last && o_out_byte == 8'h00)
        else $error("error word malformed");

    // words of one run keep the same flags
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_run_last |=> o_out_valid
            && !o_bad_char && $stable(o_string_end))
        else $error("run broken between words");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind cp1252_utf8_transcoder_core cpu8_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_byte   (o_out_byte),
    .o_bad_char   (o_bad_char),
    .o_run_last   (o_run_last),
    .o_string_end (o_string_end)
);
